// ===== sv/mzhdl_pkg.sv =====
// ----------------------------------------------------------------------------
// mzhdl_pkg
// Shared widths, codes and record types of the multi-zone demand logger.
// ----------------------------------------------------------------------------
`default_nettype none

package mzhdl_pkg;

   // sizing
   localparam int ZONES     = 3;
   localparam int LOG_DEPTH = 16;

   // fixed field widths
   localparam int FUNC_W    = 1;
   localparam int LINES_W   = 3;
   localparam int STAMP_W   = 31;
   localparam int IDX_W     = 4;
   localparam int KIND_W    = 2;
   localparam int ZONE_ID_W = 2;
   localparam int COUNT_W   = 10;
   localparam int STEP_W    = 8;

   // derived widths
   localparam int LOG_AW   = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
   localparam int FILL_W   = $clog2(LOG_DEPTH + 1);
   localparam int RB_DEPTH = ZONES + 1;
   localparam int RB_AW    = $clog2(RB_DEPTH);
   localparam int RB_CW    = $clog2(RB_DEPTH + 1);
   localparam int FSUM_W   = FILL_W + RB_CW;
   localparam int LV_W     = (ZONES > LINES_W) ? ZONES : LINES_W;
   localparam int RD_W     = ((IDX_W > LOG_AW) ? IDX_W : LOG_AW) + 2;

   // configuration port
   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   // register reset values
   localparam logic [COUNT_W-1:0] COUNT_MAX_RST = COUNT_W'(500);
   localparam logic [COUNT_W-1:0] ON_THR_RST    = COUNT_W'(400);
   localparam logic [COUNT_W-1:0] OFF_THR_RST   = COUNT_W'(100);
   localparam logic [STEP_W-1:0]  UP_STEP_RST   = STEP_W'(5);
   localparam logic [STEP_W-1:0]  DOWN_STEP_RST = STEP_W'(1);
   localparam logic [COUNT_W-1:0] COUNT_RST     = COUNT_W'(250);

   typedef enum logic [2:0] {
      REG_COUNT_MAX = 3'd0,
      REG_ON_THR    = 3'd1,
      REG_OFF_THR   = 3'd2,
      REG_UP_STEP   = 3'd3,
      REG_DOWN_STEP = 3'd4
   } reg_index_type;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_POLL     = 1'b0,
      FUNC_LOG_READ = 1'b1
   } func_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_EVENT   = 2'd0,
      KIND_SUMMARY = 2'd1,
      KIND_LOG     = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      DEM_UNKNOWN = 2'd0,
      DEM_ON      = 2'd1,
      DEM_OFF     = 2'd2
   } demand_type;

   typedef struct packed {
      logic [ZONE_ID_W-1:0] zone;
      logic                 on;
      logic [STAMP_W-1:0]   stamp;
   } log_entry_type;

   typedef struct packed {
      kind_type             kind;
      logic [ZONE_ID_W-1:0] zone_id;
      logic                 demand_on;
      logic [STAMP_W-1:0]   stamp;
      logic                 entry_valid;
      logic [STAMP_W-1:0]   poll_total;
      logic [STAMP_W-1:0]   last_change_time;
      logic                 last;
   } rsp_type;

endpackage

`default_nettype wire

// ===== sv/mzhdl_req_if.sv =====
// ----------------------------------------------------------------------------
// mzhdl_req_if
// Request channel: poll or log-read items with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mzhdl_req_if;
   logic                                valid;
   logic                                ready;
   logic [mzhdl_pkg::FUNC_W-1:0]        func;
   logic [mzhdl_pkg::LINES_W-1:0]       line_levels;
   logic [mzhdl_pkg::STAMP_W-1:0]       now_time;
   logic [mzhdl_pkg::IDX_W-1:0]         log_index;

   modport source (output valid, func, line_levels, now_time, log_index, input ready);
   modport sink   (input valid, func, line_levels, now_time, log_index, output ready);
endinterface

`default_nettype wire

// ===== sv/mzhdl_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mzhdl_rsp_if
// Result channel: events, poll summaries and log entries.
// ----------------------------------------------------------------------------
`default_nettype none

interface mzhdl_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [mzhdl_pkg::KIND_W-1:0]        kind;
   logic [mzhdl_pkg::ZONE_ID_W-1:0]     zone_id;
   logic                                demand_on;
   logic [mzhdl_pkg::STAMP_W-1:0]       stamp;
   logic                                entry_valid;
   logic [mzhdl_pkg::STAMP_W-1:0]       poll_total;
   logic [mzhdl_pkg::STAMP_W-1:0]       last_change_time;
   logic                                last;

   modport source (output valid, kind, zone_id, demand_on, stamp, entry_valid,
                   poll_total, last_change_time, last, input ready);
   modport sink   (input valid, kind, zone_id, demand_on, stamp, entry_valid,
                   poll_total, last_change_time, last, output ready);
endinterface

`default_nettype wire

// ===== sv/multi_zone_hysteresis_demand_logger.sv =====
// ----------------------------------------------------------------------------
// multi_zone_hysteresis_demand_logger
// Per-zone integrating debounce with on/off hysteresis, change events,
// a newest-first event log and a summary result per poll.
// ----------------------------------------------------------------------------
//
//   port     dir   kind        moves
//   req_bus  in    valid/ready poll (func 0) or log read (func 1)
//   rsp_bus  out   valid/ready event, poll summary or log entry
//   csr_*    in    APB write   count_max, thresholds, steps at 4*index
//
// An item is taken into an input register and worked once the result buffer
// drains; a poll with k demand changes gives k+1 results, a log read gives
// one; the output moves one result per cycle while rsp_bus.ready is high.
// The input register refills while results still wait, so req ready only
// drops when both the input register and the result buffer are occupied.
// Synchronous reset loads the register defaults, counts of 250, unknown
// demand and an empty log; log contents are not cleared, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_zone_hysteresis_demand_logger (
   input  wire                              clock,
   input  wire                              reset,
   mzhdl_req_if.sink                        req_bus,
   mzhdl_rsp_if.source                      rsp_bus,
   input  wire                              csr_psel,
   input  wire                              csr_penable,
   input  wire                              csr_pwrite,
   input  wire  [mzhdl_pkg::CSR_AW-1:0]     csr_paddr,
   input  wire  [mzhdl_pkg::CSR_DW-1:0]     csr_pwdata,
   output logic [mzhdl_pkg::CSR_DW-1:0]     csr_prdata,
   output logic                             csr_pready
);

   localparam int ZONES   = mzhdl_pkg::ZONES;
   localparam int COUNT_W = mzhdl_pkg::COUNT_W;
   localparam int STEP_W  = mzhdl_pkg::STEP_W;
   localparam int STAMP_W = mzhdl_pkg::STAMP_W;
   localparam int LOG_AW  = mzhdl_pkg::LOG_AW;
   localparam int FILL_W  = mzhdl_pkg::FILL_W;
   localparam int RB_AW   = mzhdl_pkg::RB_AW;
   localparam int RB_CW   = mzhdl_pkg::RB_CW;
   localparam int FSUM_W  = mzhdl_pkg::FSUM_W;
   localparam int RD_W    = mzhdl_pkg::RD_W;

   // configuration registers
   logic [COUNT_W-1:0] count_max_ff, on_thr_ff, off_thr_ff;
   logic [STEP_W-1:0]  up_step_ff, down_step_ff;

   // input register
   logic                               in_valid_ff;
   mzhdl_pkg::func_type                in_func_ff;
   logic [mzhdl_pkg::LINES_W-1:0]      in_lines_ff;
   logic [STAMP_W-1:0]                 in_time_ff;
   logic [mzhdl_pkg::IDX_W-1:0]        in_idx_ff;

   // block state
   logic [COUNT_W-1:0]                 counts_ff [ZONES];
   mzhdl_pkg::demand_type              demand_ff [ZONES];
   mzhdl_pkg::log_entry_type           log_ff [mzhdl_pkg::LOG_DEPTH];
   logic [LOG_AW-1:0]                  head_ff;
   logic [FILL_W-1:0]                  fill_ff;
   logic [STAMP_W-1:0]                 polls_ff;
   logic [STAMP_W-1:0]                 ctime_ff;

   // result buffer
   mzhdl_pkg::rsp_type                 res_ff [mzhdl_pkg::RB_DEPTH];
   logic [RB_AW-1:0]                   rd_ff;
   logic [RB_CW-1:0]                   cnt_ff;

   // handshake
   logic accept, pop, buf_free, fire;

   // per-zone next state
   logic [COUNT_W-1:0]                 count_in  [ZONES];
   mzhdl_pkg::demand_type              demand_in [ZONES];
   logic [ZONES-1:0]                   changed;
   logic [RB_CW-1:0]                   rank      [ZONES];
   logic [LOG_AW-1:0]                  lslot     [ZONES];
   logic [RB_CW-1:0]                   n_evt;
   logic [LOG_AW-1:0]                  head_in;
   logic [FILL_W-1:0]                  fill_in;
   logic [STAMP_W-1:0]                 polls_in;
   logic [STAMP_W-1:0]                 ctime_in;

   // log read
   logic                               rd_valid;
   logic [RD_W-1:0]                    rd_slot;
   mzhdl_pkg::log_entry_type           rd_entry;
   mzhdl_pkg::rsp_type                 log_rsp;
   mzhdl_pkg::rsp_type                 sum_rsp;
   mzhdl_pkg::rsp_type                 out_rsp;

   // ---------------------------------------------------------------------
   // handshake and flow control
   assign pop      = rsp_bus.valid && rsp_bus.ready;
   assign buf_free = (cnt_ff == '0) || ((cnt_ff == RB_CW'(1)) && pop);
   assign fire     = in_valid_ff && buf_free;
   assign req_bus.ready = !in_valid_ff || fire;
   assign accept   = req_bus.valid && req_bus.ready;

   // ---------------------------------------------------------------------
   // register write and readback
   always_ff @(posedge clock) begin
      if (reset) begin
         count_max_ff <= mzhdl_pkg::COUNT_MAX_RST;
         on_thr_ff    <= mzhdl_pkg::ON_THR_RST;
         off_thr_ff   <= mzhdl_pkg::OFF_THR_RST;
         up_step_ff   <= mzhdl_pkg::UP_STEP_RST;
         down_step_ff <= mzhdl_pkg::DOWN_STEP_RST;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         unique case (mzhdl_pkg::reg_index_type'(csr_paddr[4:2]))
            mzhdl_pkg::REG_COUNT_MAX: count_max_ff <= csr_pwdata[COUNT_W-1:0];
            mzhdl_pkg::REG_ON_THR:    on_thr_ff    <= csr_pwdata[COUNT_W-1:0];
            mzhdl_pkg::REG_OFF_THR:   off_thr_ff   <= csr_pwdata[COUNT_W-1:0];
            mzhdl_pkg::REG_UP_STEP:   up_step_ff   <= csr_pwdata[STEP_W-1:0];
            mzhdl_pkg::REG_DOWN_STEP: down_step_ff <= csr_pwdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_pready = 1'b1;

   always_comb begin
      unique case (mzhdl_pkg::reg_index_type'(csr_paddr[4:2]))
         mzhdl_pkg::REG_COUNT_MAX: csr_prdata = mzhdl_pkg::CSR_DW'(count_max_ff);
         mzhdl_pkg::REG_ON_THR:    csr_prdata = mzhdl_pkg::CSR_DW'(on_thr_ff);
         mzhdl_pkg::REG_OFF_THR:   csr_prdata = mzhdl_pkg::CSR_DW'(off_thr_ff);
         mzhdl_pkg::REG_UP_STEP:   csr_prdata = mzhdl_pkg::CSR_DW'(up_step_ff);
         mzhdl_pkg::REG_DOWN_STEP: csr_prdata = mzhdl_pkg::CSR_DW'(down_step_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_func_ff  <= mzhdl_pkg::func_type'(req_bus.func);
         in_lines_ff <= req_bus.line_levels;
         in_time_ff  <= req_bus.now_time;
         in_idx_ff   <= req_bus.log_index;
      end
   end

   // ---------------------------------------------------------------------
   // integrating counters and hysteresis, one lane per zone
   always_comb begin
      logic [mzhdl_pkg::LV_W-1:0] lines_wide;
      logic [COUNT_W:0]           sum;
      logic [COUNT_W-1:0]         c;
      lines_wide = mzhdl_pkg::LV_W'(in_lines_ff);
      for (int z = 0; z < ZONES; z++) begin
         c   = counts_ff[z];
         sum = {1'b0, c} + (COUNT_W + 1)'(up_step_ff);
         demand_in[z] = demand_ff[z];
         if (lines_wide[z]) begin
            count_in[z] = (c > COUNT_W'(down_step_ff)) ? c - COUNT_W'(down_step_ff) : '0;
            if (count_in[z] < off_thr_ff) begin
               demand_in[z] = mzhdl_pkg::DEM_OFF;
            end
         end else begin
            count_in[z] = (sum > {1'b0, count_max_ff}) ? count_max_ff : sum[COUNT_W-1:0];
            if (count_in[z] > on_thr_ff) begin
               demand_in[z] = mzhdl_pkg::DEM_ON;
            end
         end
         changed[z] = (demand_in[z] != demand_ff[z]);
      end
   end

   // ---------------------------------------------------------------------
   // event ranks and log slots in zone order
   always_comb begin
      logic [RB_CW-1:0]  n;
      logic [LOG_AW-1:0] slot;
      n    = '0;
      slot = head_ff;
      for (int z = 0; z < ZONES; z++) begin
         rank[z]  = n;
         lslot[z] = slot;
         if (changed[z]) begin
            n    = n + RB_CW'(1);
            slot = (slot == LOG_AW'(mzhdl_pkg::LOG_DEPTH - 1)) ? '0 : slot + LOG_AW'(1);
         end
      end
      n_evt   = n;
      head_in = slot;
   end

   // fill clamps at the log depth
   always_comb begin
      logic [FSUM_W-1:0] fsum;
      fsum = FSUM_W'(fill_ff) + FSUM_W'(n_evt);
      fill_in = (fsum > FSUM_W'(mzhdl_pkg::LOG_DEPTH)) ?
                FILL_W'(mzhdl_pkg::LOG_DEPTH) : fsum[FILL_W-1:0];
   end

   assign polls_in = polls_ff + STAMP_W'(1);
   assign ctime_in = (n_evt != '0) ? in_time_ff : ctime_ff;

   // poll summary
   always_comb begin
      sum_rsp                  = '0;
      sum_rsp.kind             = mzhdl_pkg::KIND_SUMMARY;
      sum_rsp.stamp            = in_time_ff;
      sum_rsp.poll_total       = polls_in;
      sum_rsp.last_change_time = ctime_in;
      sum_rsp.last             = 1'b1;
   end

   // ---------------------------------------------------------------------
   // log read, index 0 is the entry just before the head
   assign rd_valid = (FSUM_W'(in_idx_ff) < FSUM_W'(fill_ff));

   always_comb begin
      logic [RD_W-1:0] h, i;
      h = RD_W'(head_ff);
      i = RD_W'(in_idx_ff);
      if (h > i) begin
         rd_slot = h - RD_W'(1) - i;
      end else begin
         rd_slot = h + RD_W'(mzhdl_pkg::LOG_DEPTH - 1) - i;
      end
   end

   assign rd_entry = log_ff[rd_slot[LOG_AW-1:0]];

   always_comb begin
      log_rsp             = '0;
      log_rsp.kind        = mzhdl_pkg::KIND_LOG;
      log_rsp.entry_valid = rd_valid;
      log_rsp.last        = 1'b1;
      if (rd_valid) begin
         log_rsp.zone_id   = rd_entry.zone;
         log_rsp.demand_on = rd_entry.on;
         log_rsp.stamp     = rd_entry.stamp;
      end
   end

   // ---------------------------------------------------------------------
   // zone and log control state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int z = 0; z < ZONES; z++) begin
            counts_ff[z] <= mzhdl_pkg::COUNT_RST;
            demand_ff[z] <= mzhdl_pkg::DEM_UNKNOWN;
         end
         head_ff  <= '0;
         fill_ff  <= '0;
         polls_ff <= '0;
         ctime_ff <= '0;
      end else if (fire && (in_func_ff == mzhdl_pkg::FUNC_POLL)) begin
         for (int z = 0; z < ZONES; z++) begin
            counts_ff[z] <= count_in[z];
            demand_ff[z] <= demand_in[z];
         end
         head_ff  <= head_in;
         fill_ff  <= fill_in;
         polls_ff <= polls_in;
         ctime_ff <= ctime_in;
      end
   end

   // log entries and result buffer contents
   always_ff @(posedge clock) begin
      if (fire) begin
         if (in_func_ff == mzhdl_pkg::FUNC_POLL) begin
            for (int z = 0; z < ZONES; z++) begin
               if (changed[z]) begin
                  log_ff[lslot[z]] <= '{zone:  mzhdl_pkg::ZONE_ID_W'(z),
                                        on:    (demand_in[z] == mzhdl_pkg::DEM_ON),
                                        stamp: in_time_ff};
                  res_ff[rank[z][RB_AW-1:0]] <= '{
                     kind:             mzhdl_pkg::KIND_EVENT,
                     zone_id:          mzhdl_pkg::ZONE_ID_W'(z),
                     demand_on:        (demand_in[z] == mzhdl_pkg::DEM_ON),
                     stamp:            in_time_ff,
                     entry_valid:      1'b0,
                     poll_total:       '0,
                     last_change_time: '0,
                     last:             1'b0};
               end
            end
            res_ff[n_evt[RB_AW-1:0]] <= sum_rsp;
         end else begin
            res_ff[0] <= log_rsp;
         end
      end
   end

   // result buffer pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else if (fire) begin
         rd_ff  <= '0;
         cnt_ff <= (in_func_ff == mzhdl_pkg::FUNC_POLL) ? n_evt + RB_CW'(1) : RB_CW'(1);
      end else if (pop) begin
         rd_ff  <= rd_ff + RB_AW'(1);
         cnt_ff <= cnt_ff - RB_CW'(1);
      end
   end

   // ---------------------------------------------------------------------
   // result channel
   assign out_rsp                  = res_ff[rd_ff];
   assign rsp_bus.valid            = (cnt_ff != '0);
   assign rsp_bus.kind             = out_rsp.kind;
   assign rsp_bus.zone_id          = out_rsp.zone_id;
   assign rsp_bus.demand_on        = out_rsp.demand_on;
   assign rsp_bus.stamp            = out_rsp.stamp;
   assign rsp_bus.entry_valid      = out_rsp.entry_valid;
   assign rsp_bus.poll_total       = out_rsp.poll_total;
   assign rsp_bus.last_change_time = out_rsp.last_change_time;
   assign rsp_bus.last             = out_rsp.last;

   // ---------------------------------------------------------------------
   // checks

   // the log never reports more entries than it holds
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(mzhdl_pkg::LOG_DEPTH))
      else $error("log fill beyond depth");

   // a worked item always leaves a result waiting
   a_fire_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_bus.valid)
      else $error("no result after item was worked");

   // the last flag marks exactly the final buffered result
   a_last_final: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.last == (cnt_ff == RB_CW'(1))))
      else $error("last flag out of step with buffer");

   // a new item is worked only once the buffer empties
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready) |-> !fire)
      else $error("result buffer overwritten while stalled");

endmodule

`default_nettype wire
